FILE: rtl/core/udpcs_pkg.sv
package udpcs_pkg;

    localparam logic [15:0] UDP_PROTO = 16'd17;
    localparam logic [17:0] HDR_BYTES = 18'd8;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [15:0] LEN_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        NB_NONE  = 2'd0,
        NB_UPPER = 2'd1,
        NB_BOTH  = 2'd2,
        NB_BOTH3 = 2'd3
    } t_nbytes;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [15:0] payload_word;
        logic [1:0]  valid_bytes;
        logic        last_word;
    } t_in_req;

    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] udp_length;
        logic        too_long;
    } t_out_rsp;

    // closed datagram, handed from front to back
    typedef struct packed {
        logic [15:0] running_sum;
        logic [16:0] byte_count;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
    } t_dgram;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

FILE: rtl/core/udpcs_front.sv
module udpcs_front import udpcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_req   i_in,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_dgram    o_push_data
);

    logic [15:0] r_sum,   n_sum;
    logic [16:0] r_count, n_count;
    logic        r_first, n_first;
    logic [31:0] r_sip,   n_sip;
    logic [31:0] r_dip,   n_dip;
    logic [15:0] r_dport, n_dport;

    logic        w_accept;
    logic [1:0]  w_nb;
    logic [15:0] w_addend;
    logic [16:0] w_s17;
    logic [15:0] w_sum_upd;
    logic [17:0] w_cnt18;
    logic [16:0] w_cnt_upd;
    logic [31:0] w_sip;
    logic [31:0] w_dip;
    logic [15:0] w_dport;

    assign o_in_stall = i_q_status.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        case (t_nbytes'(i_in.valid_bytes))
            NB_NONE:  begin w_nb = 2'd0; w_addend = 16'h0000; end
            NB_UPPER: begin w_nb = 2'd1; w_addend = {i_in.payload_word[15:8], 8'h00}; end
            NB_BOTH:  begin w_nb = 2'd2; w_addend = i_in.payload_word; end
            NB_BOTH3: begin w_nb = 2'd2; w_addend = i_in.payload_word; end
            default:  begin w_nb = 2'd0; w_addend = 16'h0000; end
        endcase
    end

    assign w_s17     = {1'b0, r_sum} + {1'b0, w_addend};
    assign w_sum_upd = w_s17[15:0] + {15'd0, w_s17[16]};
    assign w_cnt18   = {1'b0, r_count} + {16'd0, w_nb};
    assign w_cnt_upd = w_cnt18[17] ? COUNT_MAX : w_cnt18[16:0];

    assign w_sip   = r_first ? i_in.source_ip : r_sip;
    assign w_dip   = r_first ? i_in.dest_ip   : r_dip;
    assign w_dport = r_first ? i_in.dest_port : r_dport;

    assign o_push                  = w_accept && i_in.last_word;
    assign o_push_data.running_sum = w_sum_upd;
    assign o_push_data.byte_count  = w_cnt_upd;
    assign o_push_data.source_ip   = w_sip;
    assign o_push_data.dest_ip     = w_dip;
    assign o_push_data.dest_port   = w_dport;

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_first = r_first;
        n_sip   = r_sip;
        n_dip   = r_dip;
        n_dport = r_dport;
        if (w_accept) begin
            n_sip   = w_sip;
            n_dip   = w_dip;
            n_dport = w_dport;
            if (i_in.last_word) begin
                n_sum   = 16'h0000;
                n_count = 17'd0;
                n_first = 1'b1;
            end else begin
                n_sum   = w_sum_upd;
                n_count = w_cnt_upd;
                n_first = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= 16'h0000;
            r_count <= 17'd0;
            r_first <= 1'b1;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sip   <= n_sip;
        r_dip   <= n_dip;
        r_dport <= n_dport;
    end

endmodule

FILE: rtl/core/udpcs_fifo.sv
module udpcs_fifo import udpcs_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_dgram    i_push_data,
    input  logic      i_pop,
    output t_dgram    o_pop_data,
    output t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_dgram        r_mem [DEPTH];
    logic [PW-1:0] r_wptr,  n_wptr;
    logic [PW-1:0] r_rptr,  n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_push;
    logic          w_pop;

    assign o_status.full      = (r_count == CNT_FULL);
    assign o_status.not_empty = (r_count != '0);
    assign w_push     = i_push && !o_status.full;
    assign w_pop      = i_pop && o_status.not_empty;
    assign o_pop_data = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + PW'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

FILE: rtl/core/udpcs_back.sv
module udpcs_back import udpcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_source_port,
    input  t_q_status   i_q_status,
    input  t_dgram      i_dgram,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_rsp    o_out
);

    logic        w_adv;

    logic        r_a_valid;
    logic [18:0] r_a_sum5;
    logic [17:0] r_a_sum3;
    logic [15:0] r_a_len;
    logic        r_a_over;

    logic        r_b_valid;
    logic [19:0] r_b_total;
    logic [15:0] r_b_len;
    logic        r_b_over;

    logic        r_out_valid;
    t_out_rsp    r_out;

    logic [17:0] w_total;
    logic        w_over;
    logic [15:0] w_len;
    logic [18:0] w_sum5;
    logic [17:0] w_sum3;
    logic [19:0] w_total_b;
    logic [16:0] w_f1;
    logic [15:0] w_f2;
    logic [15:0] w_ck;

    assign w_adv = !r_out_valid || !i_out_stall;
    assign o_pop = w_adv && i_q_status.not_empty;

    // stage A: length and partial sums
    assign w_total = {1'b0, i_dgram.byte_count} + HDR_BYTES;
    assign w_over  = (w_total[17:16] != 2'b00);
    assign w_len   = w_over ? LEN_MAX : w_total[15:0];
    assign w_sum5  = {3'd0, i_dgram.running_sum}
                   + {3'd0, i_dgram.source_ip[31:16]}
                   + {3'd0, i_dgram.source_ip[15:0]}
                   + {3'd0, i_dgram.dest_ip[31:16]}
                   + {3'd0, i_dgram.dest_ip[15:0]};
    assign w_sum3  = {2'd0, i_source_port} + {2'd0, i_dgram.dest_port} + {2'd0, UDP_PROTO};

    // stage B: full sum, length counted twice
    assign w_total_b = {1'b0, r_a_sum5} + {2'd0, r_a_sum3} + {3'd0, r_a_len, 1'b0};

    // fold, complement, zero sent as all ones
    assign w_f1 = {1'b0, r_b_total[15:0]} + {13'd0, r_b_total[19:16]};
    assign w_f2 = w_f1[15:0] + {15'd0, w_f1[16]};
    assign w_ck = ~w_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid   <= i_q_status.not_empty;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_sum5  <= w_sum5;
            r_a_sum3  <= w_sum3;
            r_a_len   <= w_len;
            r_a_over  <= w_over;
            r_b_total <= w_total_b;
            r_b_len   <= r_a_len;
            r_b_over  <= r_a_over;
            r_out.checksum   <= (w_ck == 16'h0000) ? LEN_MAX : w_ck;
            r_out.udp_length <= r_b_len;
            r_out.too_long   <= r_b_over;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/core/udp_checksum_generator_top.sv
// UDP checksum generator over the IPv4 pseudo-header. Send one payload as
// 16-bit big-endian words, one per cycle; addressing is taken from the first
// word of each datagram and the source port from the configuration register.
// The front end sums one word per cycle while the input is not stalled, and
// the next datagram follows the last word with no gap. Closed datagrams go
// through a QUEUE_DEPTH-entry queue into a three-stage back end (stage A,
// stage B, output register). The input stalls only while the queue is full.
// Write the source port only while idle.
module udp_checksum_generator_top import udpcs_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_rsp    o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_source_port;
    logic        w_push;
    t_dgram      w_push_data;
    logic        w_pop;
    t_dgram      w_pop_data;
    t_q_status   w_q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_port <= 16'h0000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_source_port <= i_cfg_data;
        end
    end

    udpcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    udpcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_q_status)
    );

    udpcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_source_port (r_source_port),
        .i_q_status    (w_q_status),
        .i_dgram       (w_pop_data),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out         (o_out)
    );

    a_ck_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.checksum != 16'h0000))
        else $error("checksum of zero sent");

    a_long_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.too_long) |-> (o_out.udp_length == LEN_MAX))
        else $error("too_long without saturated length");

    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.too_long) |-> (o_out.udp_length >= 16'd8))
        else $error("length below header size");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !w_push)
        else $error("push into full queue");

endmodule
